FILE: hdl/lkvt_pkg.sv
// Shared types and constants for the linear key/value table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MISS,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    // Port strobes from the sequencer to the pair store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage : lkvt_pkg

`default_nettype wire

FILE: hdl/lkvt_store.sv
// Key and value memories of the table: one write port, one registered read port.
// Depends on lkvt_pkg for the word widths and the port control struct.
`timescale 1ns / 1ps
`default_nettype none

module lkvt_store
    import lkvt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire t_mem_ctl         i_ctl,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [KEY_W-1:0] i_wkey,
    input  wire logic [VAL_W-1:0] i_wval,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [KEY_W-1:0] o_rd_key,
    output logic      [VAL_W-1:0] o_rd_val
);

    logic [KEY_W-1:0] r_key_mem [DEPTH];
    logic [VAL_W-1:0] r_val_mem [DEPTH];
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_key_mem[i_waddr] <= i_wkey;
            r_val_mem[i_waddr] <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_key <= r_key_mem[i_raddr];
            r_rd_val <= r_val_mem[i_raddr];
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_val = r_rd_val;

endmodule : lkvt_store

`default_nettype wire

FILE: hdl/linear_key_value_table.sv
// Top level of the linear key/value table: command sequencer and shared key compare.
// Depends on lkvt_pkg and instantiates lkvt_store.
`timescale 1ns / 1ps
`default_nettype none

// Table of up to DEPTH unique key/value pairs in insertion order, searched from
// entry 0 upward. A request is taken when start is high and busy is low; busy
// stays high until the single result has been shown on the o_ result ports for
// one cycle with o_strobe, which cannot be held off. All work goes through one
// memory read port with registered data: each entry visited by the search
// takes a read state and a compare state, and each entry moved down on a delete
// takes a read state and a write state. Clear goes straight to the done state. No
// clearing pass follows reset: only entries below the pair count are ever read.
module linear_key_value_table
    import lkvt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [31:0] i_key,
    input  wire logic [31:0]        i_value,
    output logic                    o_strobe,
    output logic                    o_hit,
    output logic                    o_full_res,
    output logic [COUNT_W-1:0]      o_pair_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_value, n_value;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic             r_hit, n_hit;
    logic             r_full, n_full;

    t_mem_ctl         mem_ctl;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wkey;
    logic [VAL_W-1:0] mem_wval;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;

    logic             key_eq;
    logic             more_scan;
    logic             more_shift;
    logic             has_room;

    lkvt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_ctl    (mem_ctl),
        .i_waddr  (mem_waddr),
        .i_wkey   (mem_wkey),
        .i_wval   (mem_wval),
        .i_raddr  (mem_raddr),
        .o_rd_key (rd_key),
        .o_rd_val (rd_val)
    );

    // Shared compare unit and loop bounds
    assign key_eq     = (rd_key == r_key);
    assign more_scan  = ((CW+1)'(r_idx) + (CW+1)'(1)) < (CW+1)'(r_count);
    assign more_shift = ((CW+1)'(r_idx) + (CW+1)'(2)) < (CW+1)'(r_count);
    assign has_room   = (r_count < DEPTH_C);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (t_cmd'(i_cmd) == CMD_CLEAR) begin
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (key_eq) begin
                    n_state = (r_cmd == CMD_DELETE && more_scan) ? S_SH_RD : S_DONE;
                end else begin
                    n_state = more_scan ? S_RD : S_MISS;
                end
            end
            S_MISS:  n_state = S_DONE;
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: n_state = more_shift ? S_SH_RD : S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_value = r_value;
        n_idx   = r_idx;
        n_count = r_count;
        n_hit   = r_hit;
        n_full  = r_full;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_key   = KEY_W'(unsigned'(i_key));
                    n_value = i_value;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_full  = 1'b0;
                    if (t_cmd'(i_cmd) == CMD_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            S_CMP: begin
                if (key_eq) begin
                    n_hit = (r_cmd == CMD_CHECK) ? (rd_val == r_value) : 1'b1;
                    if (r_cmd == CMD_DELETE && !more_scan) begin
                        n_count = r_count - CW'(1);
                    end
                end else if (more_scan) begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_MISS: begin
                if (r_cmd == CMD_SET) begin
                    if (has_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_full = 1'b1;
                    end
                end
            end
            S_SH_WR: begin
                n_idx = r_idx + AW'(1);
                if (!more_shift) begin
                    n_count = r_count - CW'(1);
                end
            end
            S_RD, S_SH_RD, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Outputs and memory port control
    always_comb begin
        mem_ctl   = '0;
        mem_waddr = r_idx;
        mem_wkey  = r_key;
        mem_wval  = r_value;
        mem_raddr = r_idx;
        unique case (r_state)
            S_RD: mem_ctl.rd_en = 1'b1;
            S_CMP: begin
                // overwrite value of a stored key
                mem_ctl.wr_en = key_eq && (r_cmd == CMD_SET);
            end
            S_MISS: begin
                // append new pair at the end
                mem_ctl.wr_en = (r_cmd == CMD_SET) && has_room;
                mem_waddr     = r_count[AW-1:0];
            end
            S_SH_RD: begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = r_idx + AW'(1);
            end
            S_SH_WR: begin
                // move the next entry down one place
                mem_ctl.wr_en = 1'b1;
                mem_wkey      = rd_key;
                mem_wval      = rd_val;
            end
            S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = (r_state == S_DONE);
    assign o_hit        = r_hit;
    assign o_full_res   = r_full;
    assign o_pair_count = COUNT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_full  <= n_full;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("pair count above table depth");

    a_full_only_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_full_res) |-> (r_cmd == CMD_SET && !o_hit && r_count == DEPTH_C))
        else $error("full reported outside a refused set");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_cmd == CMD_CLEAR) |-> (r_count == '0 && !o_hit))
        else $error("clear left pairs or reported a hit");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!o_strobe && !busy))
        else $error("result strobe not followed by idle");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |-> ((CW'(mem_waddr) < r_count) ||
                           (r_state == S_MISS && CW'(mem_waddr) == r_count)))
        else $error("write outside the occupied entries");

endmodule : linear_key_value_table

`default_nettype wire
